// ===== rtl/cell_stream_validator_assert.svh =====
// ----------------------------------------------------------------------------
// Cell stream validator assertion macros
// Shorthand for the concurrent checks used inside the validator.
// ----------------------------------------------------------------------------
`ifndef CELL_STREAM_VALIDATOR_ASSERT_SVH
`define CELL_STREAM_VALIDATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSV_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/csv_pkg.sv =====
// ----------------------------------------------------------------------------
// Cell stream validator package
// Parse phases, cell type codes and the per-type point count rule.
// ----------------------------------------------------------------------------
package csv_pkg;

	localparam int OFFSET_BITS = 20;
	localparam int WORD_BITS   = 32;
	localparam int COUNT_BITS  = 31;
	localparam int TYPE_BITS   = 6;
	localparam int CELLS_BITS  = 21;
	localparam int NUM_BITS    = 20;

	typedef enum logic [2:0] {
		PH_TYPE,
		PH_COUNT,
		PH_POINTS,
		PH_FACE_COUNT,
		PH_FACE_POINTS
	} phase_t;

	localparam logic [TYPE_BITS-1:0] CT_EMPTY          = 6'd0;
	localparam logic [TYPE_BITS-1:0] CT_VERTEX         = 6'd1;
	localparam logic [TYPE_BITS-1:0] CT_MULTI_VERTEX   = 6'd2;
	localparam logic [TYPE_BITS-1:0] CT_SEGMENT        = 6'd3;
	localparam logic [TYPE_BITS-1:0] CT_MULTI_SEGMENT  = 6'd4;
	localparam logic [TYPE_BITS-1:0] CT_TRIANGLE       = 6'd5;
	localparam logic [TYPE_BITS-1:0] CT_TRIANGLE_STRIP = 6'd6;
	localparam logic [TYPE_BITS-1:0] CT_NGON           = 6'd7;
	localparam logic [TYPE_BITS-1:0] CT_RECT           = 6'd8;
	localparam logic [TYPE_BITS-1:0] CT_QUAD           = 6'd9;
	localparam logic [TYPE_BITS-1:0] CT_TETRA          = 6'd10;
	localparam logic [TYPE_BITS-1:0] CT_VOXEL          = 6'd11;
	localparam logic [TYPE_BITS-1:0] CT_BRICK          = 6'd12;
	localparam logic [TYPE_BITS-1:0] CT_WEDGE          = 6'd13;
	localparam logic [TYPE_BITS-1:0] CT_PYRAMID        = 6'd14;
	localparam logic [TYPE_BITS-1:0] CT_PRISM5         = 6'd15;
	localparam logic [TYPE_BITS-1:0] CT_PRISM6         = 6'd16;
	localparam logic [TYPE_BITS-1:0] CT_FACETED        = 6'd42;
	localparam logic [TYPE_BITS-1:0] CT_OUT_OF_RANGE   = 6'd63;

	// Whether a non-negative point count suits a cell type other than a faceted cell.
	function automatic logic count_ok(input logic [TYPE_BITS-1:0] t,
			input logic [COUNT_BITS-1:0] c);
		logic ok;
		case (t) inside
			CT_EMPTY:                              ok = (c == 31'd0);
			CT_VERTEX:                             ok = (c == 31'd1);
			CT_MULTI_VERTEX:                       ok = (c >= 31'd1);
			CT_SEGMENT:                            ok = (c == 31'd2);
			CT_MULTI_SEGMENT:                      ok = (c >= 31'd2);
			CT_TRIANGLE:                           ok = (c == 31'd3);
			CT_TRIANGLE_STRIP, CT_NGON:            ok = (c >= 31'd3);
			CT_RECT, CT_QUAD, CT_TETRA:            ok = (c == 31'd4);
			CT_VOXEL, CT_BRICK:                    ok = (c == 31'd8);
			CT_WEDGE:                              ok = (c == 31'd6);
			CT_PYRAMID:                            ok = (c == 31'd5);
			CT_PRISM5:                             ok = (c == 31'd10);
			CT_PRISM6:                             ok = (c == 31'd12);
			default:                               ok = 1'b1;
		endcase
		return ok;
	endfunction

endpackage

// ===== rtl/cell_stream_validator.sv =====
// Each word passes the input register, and its result the result register. Throughput: one stream
// word per cycle unless a result waits on out_stall; parse state updates once per word, in one pass.
// A word that causes no result leaves the input register without waiting on the output side.
// Reset (arst_n low, asynchronous) empties both registers and puts the parser at a type word.
// After the last word of a stream the parser returns to that same state for the next stream.
// ----------------------------------------------------------------------------
// Cell stream validator
// Parses a cell stream word by word, reports each cell header and a final verdict.
// ----------------------------------------------------------------------------
`include "cell_stream_validator_assert.svh"

module cell_stream_validator (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [csv_pkg::WORD_BITS-1:0]   stream_word,
	input  logic                                   last_word,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic                                   cell_start,
	output logic        [csv_pkg::NUM_BITS-1:0]    cell_number,
	output logic        [csv_pkg::NUM_BITS-1:0]    cell_offset,
	output logic                                   verdict,
	output logic                                   stream_valid,
	output logic        [csv_pkg::CELLS_BITS-1:0]  cell_total
);

	localparam logic [csv_pkg::OFFSET_BITS-1:0] OFF_MAX = '1;
	localparam logic [csv_pkg::CELLS_BITS-1:0]  CELLS_MAX = '1;

	// Input register.
	logic                              valid_s1;
	logic [csv_pkg::WORD_BITS-1:0]     word_s1;
	logic                              last_s1;

	// Parse state.
	csv_pkg::phase_t                   phase_q, phase_d;
	logic [csv_pkg::TYPE_BITS-1:0]     type_q, type_d;
	logic [csv_pkg::COUNT_BITS-1:0]    points_q, points_d;
	logic [csv_pkg::COUNT_BITS-1:0]    faces_q, faces_d;
	logic [csv_pkg::OFFSET_BITS-1:0]   offset_q, offset_d;
	logic [csv_pkg::CELLS_BITS-1:0]    cells_q, cells_d;
	logic                              error_q, error_d;

	// Result register.
	logic                              out_valid_q;
	logic                              start_q;
	logic [csv_pkg::NUM_BITS-1:0]      number_q;
	logic [csv_pkg::NUM_BITS-1:0]      offset_out_q;
	logic                              verdict_q;
	logic                              good_q;
	logic [csv_pkg::CELLS_BITS-1:0]    total_q;

	logic                              res_start;
	logic                              res_good;
	logic                              has_result;
	logic                              out_free;
	logic                              advance;
	logic                              word_neg;
	logic [csv_pkg::COUNT_BITS-1:0]    word_mag;
	logic [csv_pkg::TYPE_BITS-1:0]     word_type;
	logic [31:0]                       offset_ext;

	assign word_neg  = word_s1[csv_pkg::WORD_BITS-1];
	assign word_mag  = word_s1[csv_pkg::COUNT_BITS-1:0];
	// Type codes 0 to 62 are kept; anything else collapses to the out-of-range code.
	assign word_type = (!word_neg && word_s1[csv_pkg::WORD_BITS-2:csv_pkg::TYPE_BITS] == '0)
		? word_s1[csv_pkg::TYPE_BITS-1:0] : csv_pkg::CT_OUT_OF_RANGE;
	assign offset_ext = 32'(offset_q);

	always_comb begin
		phase_d   = phase_q;
		type_d    = type_q;
		points_d  = points_q;
		faces_d   = faces_q;
		offset_d  = offset_q;
		cells_d   = cells_q;
		error_d   = error_q;
		res_start = 1'b0;

		if (!error_q) begin
			unique case (phase_q)
				csv_pkg::PH_TYPE: begin
					res_start = 1'b1;
					if (cells_q != CELLS_MAX)
						cells_d = cells_q + 1'b1;
					type_d  = word_type;
					phase_d = csv_pkg::PH_COUNT;
				end
				csv_pkg::PH_COUNT: begin
					if (word_neg || last_s1) begin
						error_d = 1'b1;
					end else if (type_q == csv_pkg::CT_FACETED) begin
						if (word_mag < 31'd3) begin
							error_d = 1'b1;
						end else begin
							faces_d = word_mag;
							phase_d = csv_pkg::PH_FACE_COUNT;
						end
					end else if (!csv_pkg::count_ok(type_q, word_mag)) begin
						error_d = 1'b1;
					end else begin
						points_d = word_mag;
						phase_d  = (word_mag != '0) ? csv_pkg::PH_POINTS : csv_pkg::PH_TYPE;
					end
				end
				csv_pkg::PH_FACE_COUNT: begin
					if (word_neg || word_mag < 31'd3) begin
						error_d = 1'b1;
					end else begin
						points_d = word_mag;
						phase_d  = csv_pkg::PH_FACE_POINTS;
					end
				end
				csv_pkg::PH_POINTS: begin
					points_d = points_q - 1'b1;
					if (points_q == 31'd1)
						phase_d = csv_pkg::PH_TYPE;
				end
				csv_pkg::PH_FACE_POINTS: begin
					points_d = points_q - 1'b1;
					if (points_q == 31'd1) begin
						faces_d = faces_q - 1'b1;
						phase_d = (faces_q != 31'd1) ? csv_pkg::PH_FACE_COUNT
							: csv_pkg::PH_TYPE;
					end
				end
				default: begin
					error_d = 1'b1;
				end
			endcase
		end

		// The offset saturates; a further non-last word means the stream is too long.
		if (!last_s1) begin
			if (offset_q == OFF_MAX)
				error_d = 1'b1;
			else
				offset_d = offset_q + 1'b1;
		end

		res_good = last_s1 && !error_d && (phase_d == csv_pkg::PH_TYPE);
	end

	assign has_result = res_start || last_s1;
	assign out_free   = !out_valid_q || !out_stall;
	assign advance    = valid_s1 && (!has_result || out_free);
	assign in_stall   = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			word_s1 <= stream_word;
			last_s1 <= last_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= csv_pkg::PH_TYPE;
			type_q   <= '0;
			points_q <= '0;
			faces_q  <= '0;
			offset_q <= '0;
			cells_q  <= '0;
			error_q  <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				// The closing word of a stream readies the parser for the next one.
				phase_q  <= csv_pkg::PH_TYPE;
				type_q   <= '0;
				points_q <= '0;
				faces_q  <= '0;
				offset_q <= '0;
				cells_q  <= '0;
				error_q  <= 1'b0;
			end else begin
				phase_q  <= phase_d;
				type_q   <= type_d;
				points_q <= points_d;
				faces_q  <= faces_d;
				offset_q <= offset_d;
				cells_q  <= cells_d;
				error_q  <= error_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			start_q      <= res_start;
			number_q     <= res_start ? cells_q[csv_pkg::NUM_BITS-1:0] : '0;
			offset_out_q <= res_start ? offset_ext[csv_pkg::NUM_BITS-1:0] : '0;
			verdict_q    <= last_s1;
			good_q       <= res_good;
			total_q      <= last_s1 ? cells_d : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign cell_start   = start_q;
	assign cell_number  = number_q;
	assign cell_offset  = offset_out_q;
	assign verdict      = verdict_q;
	assign stream_valid = good_q;
	assign cell_total   = total_q;

	`CSV_ASSERT_SAME(a_result_has_cause, out_valid_q, start_q || verdict_q, "result with no cause")
	`CSV_ASSERT_SAME(a_good_needs_cell, out_valid_q && good_q, verdict_q && total_q != '0, "valid stream without a cell")
	`CSV_ASSERT_SAME(a_no_start_after_error, advance && error_q, !res_start, "cell header after error")
	`CSV_ASSERT_NEXT(a_stream_end_clears, advance && last_s1, offset_q == '0 && cells_q == '0 && !error_q, "state not cleared")

endmodule
